// ===== rtl/switch_command_frame_parser_core_defines.svh =====
// Assertion macros shared by the switch command frame parser RTL.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is asserted.
`ifndef SWITCH_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define SWITCH_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define SCFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define SCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scfp_pkg.sv =====
// ----------------------------------------------------------------------------
// scfp_pkg
// Byte codes, status and group codes, and the frame descriptor type shared
// by the parser front end, the descriptor queue and the decode back end.
// ----------------------------------------------------------------------------
package scfp_pkg;

    // Default receive buffer size, in data bytes
    localparam int BUFFER_BYTES_DEFAULT = 64;

    // Depth of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Framing bytes
    localparam logic [7:0] SYNC_BYTE     = 8'h56;
    localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
    localparam logic [7:0] CMD_HI_FLOOR  = 8'hF0;
    localparam logic [7:0] END_BYTE      = 8'hCC;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;

    // Command high bytes per target group
    localparam logic [7:0] CMD_HI_USB = 8'hF1;
    localparam logic [7:0] CMD_HI_SD  = 8'hF2;
    localparam logic [7:0] CMD_HI_HUB = 8'hF3;
    localparam logic [7:0] CMD_HI_AUX = 8'hF4;

    // Command low bytes
    localparam logic [7:0] CMD_LO_ENABLE  = 8'h01;
    localparam logic [7:0] CMD_LO_DISABLE = 8'h02;

    // Frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYNC = 2'd1;
    localparam logic [1:0] STATUS_BAD_CMD  = 2'd2;
    localparam logic [1:0] STATUS_ZERO_DAT = 2'd3;

    // Target group codes
    localparam logic [2:0] GRP_NONE = 3'd0;
    localparam logic [2:0] GRP_USB  = 3'd1;
    localparam logic [2:0] GRP_SD   = 3'd2;
    localparam logic [2:0] GRP_HUB  = 3'd3;
    localparam logic [2:0] GRP_AUX  = 3'd4;

    // Index limits
    localparam logic [7:0] USB_INDEX_MAX   = 8'd30;
    localparam logic [7:0] SMALL_INDEX_MAX = 8'd3;
    localparam logic [7:0] USB_PER_HUB     = 8'd10;

    // x / 10 == (x * 205) >> 11 for every 8-bit x
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    // One finished frame, as handed from front to back
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] cmd;
        logic [7:0]  first_data;
        logic [6:0]  count;
    } frame_desc_t;

endpackage

// ===== rtl/switch_command_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// switch_command_frame_parser_core
// Parses received bytes into switch command frames and reports one result
// per frame, completed or rejected.
// ----------------------------------------------------------------------------
// Usage: push one received byte per cycle while full is low; every byte is
// taken by the byte parser as it is accepted. A byte that ends a frame (the
// closing 0xCC, or any byte that rejects the frame) places a frame
// descriptor into a two-entry queue; the decode stage moves it into the
// result register once that is free or being popped, and it waits on the
// result ports while empty is low. A result popped each cycle frees the
// register for the next one in the same cycle, so results also flow at one
// per cycle. full rises only when the queue holds two frames that have
// not moved on because results are not popped. No clearing pass after reset.
// ----------------------------------------------------------------------------
module switch_command_frame_parser_core
    import scfp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  frame_status,
    output logic [15:0] command_code,
    output logic [2:0]  target_group,
    output logic [7:0]  switch_index,
    output logic        switch_enable,
    output logic        index_in_range,
    output logic [7:0]  hub_number,
    output logic [6:0]  data_count
);

    logic        byte_accept;
    logic        front_valid;
    frame_desc_t front_desc;
    frame_desc_t queue_desc;
    logic        queue_empty;
    logic        queue_take;

    assign byte_accept = push && !full;

    // Byte parser
    scfp_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .rx_byte    (rx_byte),
        .desc_valid (front_valid),
        .desc       (front_desc)
    );

    // Frame descriptor queue
    scfp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_desc),
        .rd_en   (queue_take),
        .rd_data (queue_desc),
        .full    (full),
        .empty   (queue_empty)
    );

    // Decode and result register
    scfp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .desc_valid     (!queue_empty),
        .desc           (queue_desc),
        .desc_take      (queue_take),
        .pop            (pop),
        .empty          (empty),
        .frame_status   (frame_status),
        .command_code   (command_code),
        .target_group   (target_group),
        .switch_index   (switch_index),
        .switch_enable  (switch_enable),
        .index_in_range (index_in_range),
        .hub_number     (hub_number),
        .data_count     (data_count)
    );

endmodule

// ===== rtl/scfp_front.sv =====
// ----------------------------------------------------------------------------
// scfp_front
// Byte-level frame parser. Takes one byte per accept and emits a frame
// descriptor on the byte that ends a frame, good or rejected.
// ----------------------------------------------------------------------------
module scfp_front
    import scfp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic [7:0]  rx_byte,
    output logic        desc_valid,
    output frame_desc_t desc
);

    // Data count saturates at the buffer size, capped by the 7-bit count
    localparam logic [6:0] CountCap = (BUFFER_BYTES > 127) ? 7'd127 : 7'(BUFFER_BYTES);

    typedef enum logic [4:0] {
        ST_SYNC     = 5'b00001,
        ST_PREAMBLE = 5'b00010,
        ST_CMD_HI   = 5'b00100,
        ST_CMD_LO   = 5'b01000,
        ST_DATA     = 5'b10000
    } parse_state_t;

    parse_state_t step_reg, step_next;
    logic [15:0]  cmd_reg, cmd_next;
    logic [7:0]   first_reg, first_next;
    logic [6:0]   count_reg, count_next;
    logic [15:0]  cmd_word;

    assign cmd_word = {cmd_reg[15:8], rx_byte};

    // Parse step and frame end detection
    always_comb
    begin
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        first_next = first_reg;
        count_next = count_reg;
        desc_valid = 1'b0;
        desc       = '0;
        if (byte_valid)
        begin
            case (step_reg)
                ST_PREAMBLE:
                begin
                    if (rx_byte != PREAMBLE_BYTE)
                    begin
                        desc_valid  = 1'b1;
                        desc.status = STATUS_BAD_SYNC;
                        step_next   = ST_SYNC;
                        cmd_next    = '0;
                        first_next  = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        step_next = ST_CMD_HI;
                    end
                end
                ST_CMD_HI:
                begin
                    if (rx_byte <= CMD_HI_FLOOR)
                    begin
                        desc_valid  = 1'b1;
                        desc.status = STATUS_BAD_CMD;
                        step_next   = ST_SYNC;
                        cmd_next    = '0;
                        first_next  = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        cmd_next  = {rx_byte, ZERO_BYTE};
                        step_next = ST_CMD_LO;
                    end
                end
                ST_CMD_LO:
                begin
                    // zero command cannot follow a valid high byte; checked anyway
                    if (cmd_word == 16'h0000)
                    begin
                        desc_valid  = 1'b1;
                        desc.status = STATUS_BAD_CMD;
                        step_next   = ST_SYNC;
                        cmd_next    = '0;
                        first_next  = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        cmd_next   = cmd_word;
                        first_next = '0;
                        count_next = '0;
                        step_next  = ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    if (rx_byte == END_BYTE)
                    begin
                        desc_valid      = 1'b1;
                        desc.status     = STATUS_OK;
                        desc.cmd        = cmd_reg;
                        desc.first_data = first_reg;
                        desc.count      = count_reg;
                        step_next       = ST_SYNC;
                        cmd_next        = '0;
                        first_next      = '0;
                        count_next      = '0;
                    end
                    else if (rx_byte == ZERO_BYTE)
                    begin
                        desc_valid  = 1'b1;
                        desc.status = STATUS_ZERO_DAT;
                        desc.count  = count_reg;
                        step_next   = ST_SYNC;
                        cmd_next    = '0;
                        first_next  = '0;
                        count_next  = '0;
                    end
                    else if (count_reg < CountCap)
                    begin
                        // bytes past the buffer size are dropped
                        if (count_reg == 7'd0)
                        begin
                            first_next = rx_byte;
                        end
                        count_next = count_reg + 7'd1;
                    end
                end
                default:
                begin
                    // waiting for sync
                    cmd_next   = '0;
                    first_next = '0;
                    count_next = '0;
                    if (rx_byte != SYNC_BYTE)
                    begin
                        desc_valid  = 1'b1;
                        desc.status = STATUS_BAD_SYNC;
                        step_next   = ST_SYNC;
                    end
                    else
                    begin
                        step_next = ST_PREAMBLE;
                    end
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_SYNC;
            cmd_reg   <= '0;
            first_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            cmd_reg   <= cmd_next;
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/scfp_fifo.sv =====
// ----------------------------------------------------------------------------
// scfp_fifo
// Short descriptor queue between the parser front end and the decode back
// end, so either side can stall without stopping the other.
// ----------------------------------------------------------------------------
`include "switch_command_frame_parser_core_defines.svh"

module scfp_fifo
    import scfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  frame_desc_t wr_data,
    input  logic        rd_en,
    output frame_desc_t rd_data,
    output logic        full,
    output logic        empty
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

    frame_desc_t         entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;

    assign full    = (count_reg == DepthCnt);
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + CntW'(1);
            2'b01:   count_next = count_reg - CntW'(1);
            default: count_next = count_reg;
        endcase
    end

    // Pointers wrap naturally, depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `SCFP_ASSERT_IMPLIES(a_no_write_full, clk, rst_n, wr_en, !full, "write into full queue")
    `SCFP_ASSERT_IMPLIES(a_no_read_empty, clk, rst_n, rd_en, !empty, "read from empty queue")
    `SCFP_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= DepthCnt, "count overflow")
    `SCFP_ASSERT_NEXT(a_drain, clk, rst_n, rd_en && !wr_en, count_reg == $past(count_reg) - CntW'(1), "count not decremented")

endmodule

// ===== rtl/scfp_back.sv =====
// ----------------------------------------------------------------------------
// scfp_back
// Decodes a frame descriptor into the switch action and holds the result
// in an output register until it is popped.
// ----------------------------------------------------------------------------
module scfp_back
    import scfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        desc_valid,
    input  frame_desc_t desc,
    output logic        desc_take,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  frame_status,
    output logic [15:0] command_code,
    output logic [2:0]  target_group,
    output logic [7:0]  switch_index,
    output logic        switch_enable,
    output logic        index_in_range,
    output logic [7:0]  hub_number,
    output logic [6:0]  data_count
);

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] cmd_reg;
    logic [2:0]  group_reg;
    logic [7:0]  index_reg;
    logic        enable_reg;
    logic        in_range_reg;
    logic [7:0]  hub_reg;
    logic [6:0]  count_reg;

    logic [7:0]  cmd_hi;
    logic [7:0]  cmd_lo;
    logic        known_cmd;
    logic [2:0]  group_next;
    logic [7:0]  index_next;
    logic        enable_next;
    logic        in_range_next;
    logic [7:0]  hub_next;
    logic [7:0]  idx_less1;
    logic [15:0] div_prod;
    logic [7:0]  usb_hub;

    assign cmd_hi = desc.cmd[15:8];
    assign cmd_lo = desc.cmd[7:0];
    assign known_cmd = (cmd_hi >= CMD_HI_USB) && (cmd_hi <= CMD_HI_AUX)
                    && ((cmd_lo == CMD_LO_ENABLE) || (cmd_lo == CMD_LO_DISABLE));

    // Usb hub: (index - 1) / 10 + 1, index zero maps to hub one
    assign idx_less1 = desc.first_data - 8'd1;
    assign div_prod  = {8'd0, idx_less1} * {8'd0, DIV10_MUL};
    assign usb_hub   = (desc.first_data == 8'd0) ? 8'd1
                     : (8'(div_prod[15:DIV10_SHIFT]) + 8'd1);

    // Switch action decode
    always_comb
    begin
        group_next    = GRP_NONE;
        index_next    = '0;
        enable_next   = 1'b0;
        in_range_next = 1'b0;
        hub_next      = '0;
        if (known_cmd)
        begin
            group_next  = cmd_hi[2:0];
            enable_next = (cmd_lo == CMD_LO_ENABLE);
            index_next  = desc.first_data;
            case (cmd_hi[2:0])
                GRP_USB:
                begin
                    in_range_next = (desc.first_data >= 8'd1)
                                 && (desc.first_data <= USB_INDEX_MAX);
                    hub_next      = enable_next ? usb_hub : 8'd0;
                end
                GRP_HUB:
                begin
                    in_range_next = 1'b1;
                    hub_next      = enable_next ? desc.first_data : 8'd0;
                    index_next    = enable_next ? desc.first_data : 8'd0;
                end
                default:
                begin
                    // sd and aux
                    in_range_next = (desc.first_data >= 8'd1)
                                 && (desc.first_data <= SMALL_INDEX_MAX);
                    hub_next      = enable_next ? desc.first_data : 8'd0;
                end
            endcase
        end
    end

    // Take a descriptor when the output register is free or being popped
    assign desc_take = desc_valid && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (desc_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (desc_take)
        begin
            status_reg   <= desc.status;
            cmd_reg      <= desc.cmd;
            group_reg    <= group_next;
            index_reg    <= index_next;
            enable_reg   <= enable_next;
            in_range_reg <= in_range_next;
            hub_reg      <= hub_next;
            count_reg    <= desc.count;
        end
    end

    assign empty          = !out_valid_reg;
    assign frame_status   = status_reg;
    assign command_code   = cmd_reg;
    assign target_group   = group_reg;
    assign switch_index   = index_reg;
    assign switch_enable  = enable_reg;
    assign index_in_range = in_range_reg;
    assign hub_number     = hub_reg;
    assign data_count     = count_reg;

endmodule

// ===== tb/sv/tb_switch_command_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_switch_command_frame_parser_core
// Streams received bytes into the frame parser and checks every frame result
// against an in-bench predictor: directed frames first, then random frames
// (mostly well formed, some broken, some noise) under random push and pop
// gaps, with one long pop hold-off that backs the block up to full.
// ----------------------------------------------------------------------------
module tb_switch_command_frame_parser_core
    import scfp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET   = 1750;
    localparam int QUIET_FROM    = 1500;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 100;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int COUNT_CAP     = (BUFFER_BYTES_DEFAULT > 127) ? 127 : BUFFER_BYTES_DEFAULT;

    // Parser position within a frame
    typedef enum logic [2:0] {
        ST_SYNC,
        ST_PREAMBLE,
        ST_CMD_HI,
        ST_CMD_LO,
        ST_DATA
    } parse_step_t;

    // One frame result as seen on the result ports
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] cmd;
        logic [2:0]  grp;
        logic [7:0]  idx;
        logic        en;
        logic        ok;
        logic [7:0]  hub;
        logic [6:0]  cnt;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // Frame scoreboard: tracks parser state and queues expected frame results
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        frame_result_t pending_frames[$];
        int            errors;
        int            frames_checked;
        int            status_hits[4];
        parse_step_t   step;
        logic [15:0]   cmd_word;
        logic [7:0]    first_byte;
        logic [6:0]    n_data;

        function new();
            errors = 0;
            frames_checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            step       = ST_SYNC;
            cmd_word   = '0;
            first_byte = '0;
            n_data     = '0;
        endfunction

        function void reject_frame(logic [1:0] status, logic [6:0] cnt);
            frame_result_t r;
            r        = '0;
            r.status = status;
            r.cnt    = cnt;
            pending_frames.push_back(r);
            clear_frame();
        endfunction

        // Decode the finished command into a switch action
        function void complete_frame();
            frame_result_t r;
            logic [7:0]    hi;
            logic [7:0]    lo;
            r      = '0;
            hi     = cmd_word[15:8];
            lo     = cmd_word[7:0];
            r.status = STATUS_OK;
            r.cmd  = cmd_word;
            r.cnt  = n_data;
            if (hi >= CMD_HI_USB && hi <= CMD_HI_AUX &&
                (lo == CMD_LO_ENABLE || lo == CMD_LO_DISABLE))
            begin
                r.grp = 3'(hi - CMD_HI_FLOOR);
                r.en  = (lo == CMD_LO_ENABLE);
                r.idx = first_byte;
                if (r.grp == GRP_USB)
                begin
                    r.ok = (r.idx >= 1 && r.idx <= USB_INDEX_MAX);
                    if (r.en)
                        r.hub = (r.idx == 0) ? 8'd1 : 8'((r.idx - 1) / USB_PER_HUB + 1);
                end
                else if (r.grp == GRP_HUB)
                begin
                    r.ok = 1'b1;
                    if (r.en)
                        r.hub = r.idx;
                    else
                        r.idx = '0;
                end
                else
                begin
                    r.ok = (r.idx >= 1 && r.idx <= SMALL_INDEX_MAX);
                    if (r.en)
                        r.hub = r.idx;
                end
            end
            pending_frames.push_back(r);
            clear_frame();
        endfunction

        // Advance the predicted parser by one accepted byte
        function void note_byte(logic [7:0] b);
            case (step)
                ST_PREAMBLE:
                    if (b != PREAMBLE_BYTE)
                        reject_frame(STATUS_BAD_SYNC, '0);
                    else
                        step = ST_CMD_HI;
                ST_CMD_HI:
                    if (b <= CMD_HI_FLOOR)
                        reject_frame(STATUS_BAD_CMD, '0);
                    else
                    begin
                        cmd_word = {b, ZERO_BYTE};
                        step     = ST_CMD_LO;
                    end
                ST_CMD_LO:
                begin
                    cmd_word[7:0] = b;
                    if (cmd_word == '0)
                        reject_frame(STATUS_BAD_CMD, '0);
                    else
                    begin
                        first_byte = '0;
                        n_data     = '0;
                        step       = ST_DATA;
                    end
                end
                ST_DATA:
                    if (b == END_BYTE)
                        complete_frame();
                    else if (b == ZERO_BYTE)
                        reject_frame(STATUS_ZERO_DAT, n_data);
                    else if (n_data < COUNT_CAP)
                    begin
                        if (n_data == 0)
                            first_byte = b;
                        n_data++;
                    end
                default:
                    if (b != SYNC_BYTE)
                        reject_frame(STATUS_BAD_SYNC, '0);
                    else
                    begin
                        clear_frame();
                        step = ST_PREAMBLE;
                    end
            endcase
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                $error("frame %0d field %s: expected 0x%0h, got 0x%0h",
                       frames_checked, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare a popped frame result with the oldest expected one
        function void check_result(frame_result_t got);
            frame_result_t want;
            if (pending_frames.size() == 0)
            begin
                $error("unexpected frame result, status %0d cmd 0x%0h",
                       got.status, got.cmd);
                errors++;
                return;
            end
            want = pending_frames.pop_front();
            compare_field("frame_status", want.status, got.status);
            compare_field("command_code", want.cmd, got.cmd);
            compare_field("target_group", want.grp, got.grp);
            compare_field("switch_index", want.idx, got.idx);
            compare_field("switch_enable", want.en, got.en);
            compare_field("index_in_range", want.ok, got.ok);
            compare_field("hub_number", want.hub, got.hub);
            compare_field("data_count", want.cnt, got.cnt);
            status_hits[want.status]++;
            frames_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  frame_status;
    logic [15:0] command_code;
    logic [2:0]  target_group;
    logic [7:0]  switch_index;
    logic        switch_enable;
    logic        index_in_range;
    logic [7:0]  hub_number;
    logic [6:0]  data_count;

    switch_command_frame_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .frame_status   (frame_status),
        .command_code   (command_code),
        .target_group   (target_group),
        .switch_index   (switch_index),
        .switch_enable  (switch_enable),
        .index_in_range (index_in_range),
        .hub_number     (hub_number),
        .data_count     (data_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    frame_scoreboard sb = new();
    int bytes_sent = 0;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;
    int idle_count = 0;

    // ------------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Data byte that keeps the frame going: never zero, never the end byte
    function automatic logic [7:0] data_byte(bit leading);
        logic [7:0] v;
        v = (leading && $urandom_range(0, 1)) ? 8'($urandom_range(0, 35))
                                              : 8'($urandom_range(0, 255));
        if (v == ZERO_BYTE)
            v = 8'h01;
        if (v == END_BYTE)
            v = END_BYTE + 8'h01;
        return v;
    endfunction

    // Command header: sync, preamble, high and low command bytes
    task automatic send_header();
        logic [7:0] hi;
        logic [7:0] lo;
        hi = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(CMD_HI_USB, CMD_HI_AUX))
                                          : 8'($urandom_range(CMD_HI_FLOOR + 1, 255));
        if ($urandom_range(0, 99) < 85)
            lo = $urandom_range(0, 1) ? CMD_LO_ENABLE : CMD_LO_DISABLE;
        else
            lo = 8'($urandom_range(0, 255));
        send_byte(SYNC_BYTE);
        send_byte(PREAMBLE_BYTE);
        send_byte(hi);
        send_byte(lo);
    endtask

    // One random frame: mostly well formed, some broken, some noise
    task automatic send_frame();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        n    = ($urandom_range(0, 99) < 3) ? $urandom_range(COUNT_CAP - 4, COUNT_CAP + 6)
                                           : $urandom_range(0, 4);
        if (kind < 78)
        begin
            send_header();
            for (int i = 0; i < n; i++)
                send_byte(data_byte(i == 0));
            // zero data byte aborts, else the end byte closes the frame
            send_byte(kind < 70 ? END_BYTE : ZERO_BYTE);
        end
        else if (kind < 84)
        begin
            send_byte(SYNC_BYTE);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 90)
        begin
            send_byte(SYNC_BYTE);
            send_byte(PREAMBLE_BYTE);
            send_byte(8'($urandom_range(0, CMD_HI_FLOOR)));
        end
        else
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        frame_result_t got;
        int            stall_left;
        int            hold_left;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.status = frame_status;
                got.cmd    = command_code;
                got.grp    = target_group;
                got.idx    = switch_index;
                got.en     = switch_enable;
                got.ok     = index_in_range;
                got.hub    = hub_number;
                got.cnt    = data_count;
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles in a row with no handshake on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_count <= 0;
        else if (idle_count >= STALL_LIMIT)
        begin
            $display("tb_switch_command_frame_parser_core: errors");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] directed_bytes[$];
        bit         hold_done;
        hold_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bad sync, bad preamble, low command byte, usb enable with
        // no data (index 0), hub disable, zero data byte abort
        directed_bytes = '{8'hFF,
                           SYNC_BYTE, 8'h55,
                           SYNC_BYTE, PREAMBLE_BYTE, CMD_HI_FLOOR,
                           SYNC_BYTE, PREAMBLE_BYTE, CMD_HI_USB, CMD_LO_ENABLE, END_BYTE,
                           SYNC_BYTE, PREAMBLE_BYTE, CMD_HI_HUB, CMD_LO_DISABLE, 8'h07,
                           END_BYTE,
                           SYNC_BYTE, PREAMBLE_BYTE, CMD_HI_SD, CMD_LO_ENABLE, 8'h05,
                           ZERO_BYTE};
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // Random frames; one long pop hold-off partway through
        while (bytes_sent < BYTE_TARGET)
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            quiet = (bytes_sent >= QUIET_FROM);
            send_frame();
        end
        push <= 1'b0;

        // Drain
        while (sb.pending_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("bytes sent %0d, frames checked %0d", bytes_sent, sb.frames_checked);
        $display("complete %0d, bad sync %0d, bad command %0d, zero data %0d",
                 sb.status_hits[STATUS_OK], sb.status_hits[STATUS_BAD_SYNC],
                 sb.status_hits[STATUS_BAD_CMD], sb.status_hits[STATUS_ZERO_DAT]);
        if (sb.errors == 0)
            $display("tb_switch_command_frame_parser_core: clean");
        else
            $display("tb_switch_command_frame_parser_core: errors");
        $finish;
    end

endmodule
